@@ rtl/swcr_pkg.sv @@
// swcr_pkg: shared widths, defaults and the sequencer state type for the
// sliding window clock regression unit. No dependencies.
package swcr_pkg;

  localparam int EPOCH_W    = 32;  // remote overflow epoch
  localparam int TICK_W     = 16;  // remote tick counter
  localparam int COUNT_W    = EPOCH_W + TICK_W;  // full remote count
  localparam int STAMP_W    = 63;  // local time in ns
  localparam int VALUE_W    = 64;  // gain, offset and estimate
  localparam int FRAC_W     = 32;  // fraction bits of the gain
  localparam int WINDOW_DEF = 16;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_UP_READ,
    ST_UP_WRITE,
    ST_UP_XX_OLD,
    ST_UP_XY_OLD,
    ST_UP_XX_NEW,
    ST_UP_XY_NEW,
    ST_UP_NSXX,
    ST_UP_SXSX,
    ST_UP_CHECK,
    ST_UP_NSXY,
    ST_UP_SXSY,
    ST_UP_SXXSY,
    ST_UP_SXSXY,
    ST_DG_CC,
    ST_DG_NCC,
    ST_DG_CSY,
    ST_UP_DIVG,
    ST_UP_DIVO,
    ST_CV_MUL,
    ST_CV_ADD,
    ST_CV_RND,
    ST_RESULT
  } state_t;

endpackage

@@ rtl/swcr_if.sv @@
// swcr_if: request and result channels of the clock regression unit.
// Depends on swcr_pkg for field widths.
interface swcr_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [swcr_pkg::EPOCH_W-1:0]  remote_epoch;
  logic [swcr_pkg::TICK_W-1:0]   remote_ticks;
  logic [swcr_pkg::STAMP_W-1:0]  local_stamp;

  modport source (output valid, kind, remote_epoch, remote_ticks, local_stamp,
                  input ready);
  modport sink (input valid, kind, remote_epoch, remote_ticks, local_stamp,
                output ready);
endinterface

interface swcr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [swcr_pkg::VALUE_W-1:0] gain_now;
  logic signed [swcr_pkg::VALUE_W-1:0] offset_now;
  logic signed [swcr_pkg::VALUE_W-1:0] local_estimate;
  logic                                estimate_clipped;

  modport source (output valid, gain_now, offset_now, local_estimate, estimate_clipped,
                  input ready);
  modport sink (input valid, gain_now, offset_now, local_estimate, estimate_clipped,
                output ready);
endinterface

@@ rtl/swcr_mul.sv @@
// swcr_mul: bit-serial shift-add multiplier, one multiplier bit per cycle.
// Standalone; used by the clock regression top level.
module swcr_mul #(
  parameter int AW = 64,
  parameter int BW = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] prod
);

  localparam int CW = $clog2(BW + 1);

  logic [CW-1:0]    cnt;
  logic [AW-1:0]    areg;
  logic [BW-1:0]    breg;
  logic [AW+BW-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CW'(1)) && !start;
      if (start) begin
        cnt <= CW'(BW);
      end else if (cnt != '0) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  // msb first: acc = 2*acc + bit*a
  always_ff @(posedge clk) begin
    if (start) begin
      areg <= a;
      breg <= b;
      acc  <= '0;
    end else if (cnt != '0) begin
      acc  <= {acc[AW+BW-2:0], 1'b0} + (breg[BW-1] ? (AW+BW)'(areg) : '0);
      breg <= {breg[BW-2:0], 1'b0};
    end
  end

  assign prod = acc;

endmodule

@@ rtl/swcr_div.sv @@
// swcr_div: restoring divider, one quotient bit per cycle, then a rounding
// step (nearest, ties up on magnitudes). Standalone.
module swcr_div #(
  parameter int NUMW = 128,
  parameter int DW   = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NUMW-1:0] num,
  input  logic [DW-1:0]   den,
  output logic            done,
  output logic [NUMW-1:0] quo
);

  localparam int CW = $clog2(NUMW + 2);

  logic [CW-1:0]   cnt;
  logic [NUMW-1:0] nsh;
  logic [DW-1:0]   dreg;
  logic [DW-1:0]   rem;
  logic [DW:0]     r2;
  logic            ge;
  logic            rnd;

  assign r2  = {rem, nsh[NUMW-1]};
  assign ge  = r2 >= {1'b0, dreg};
  assign rnd = {rem, 1'b0} >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CW'(1)) && !start;
      if (start) begin
        cnt <= CW'(NUMW + 1);
      end else if (cnt != '0) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh  <= num;
      dreg <= den;
      rem  <= '0;
      quo  <= '0;
    end else if (cnt > CW'(1)) begin
      rem <= ge ? DW'(r2 - {1'b0, dreg}) : r2[DW-1:0];
      quo <= {quo[NUMW-2:0], ge};
      nsh <= {nsh[NUMW-2:0], 1'b0};
    end else if (cnt == CW'(1)) begin
      // remainder at least half the divisor rounds away from zero
      if (rnd) begin
        quo <= quo + NUMW'(1);
      end
    end
  end

endmodule

@@ rtl/sliding_window_clock_regression_unit.sv @@
// Sliding window clock regression unit: keeps a ring of WINDOW (remote count,
// local time) rows, refits gain and offset after each update request by least
// squares, and converts remote counts to local time on convert requests.
// Depends on swcr_pkg, swcr_if, swcr_mul and swcr_div.
//
// An update keeps the four window sums current by taking out the overwritten
// row and adding the new one, then solves the fit exactly with one bit-serial
// multiplier (one multiplier bit a cycle) and one restoring divider (one
// quotient bit a cycle). An update takes ten products and 2 quotients (nine
// products when all stored counts are equal); a convert takes one product.
// One request is worked at a time; a new request is taken while the previous
// result still waits in the output register. There is no clearing pass after
// reset: each row has a valid bit and reads as (1,1) until written.
module sliding_window_clock_regression_unit #(
  parameter int WINDOW = swcr_pkg::WINDOW_DEF
) (
  input  logic       clk,
  input  logic       rst,
  swcr_in_if.sink    item,
  swcr_out_if.source result
);

  localparam int XW   = swcr_pkg::COUNT_W;
  localparam int YW   = swcr_pkg::STAMP_W;
  localparam int VW   = swcr_pkg::VALUE_W;
  localparam int FW   = swcr_pkg::FRAC_W;
  localparam int LG   = $clog2(WINDOW);
  localparam int NW   = $clog2(WINDOW + 1);
  localparam int SXW  = XW + LG;
  localparam int SYW  = YW + LG;
  localparam int SXXW = 2 * XW + LG;
  localparam int SXYW = XW + YW + LG;
  localparam int AW   = SXYW;
  localparam int BW   = SYW;
  localparam int PW   = AW + BW;
  localparam int DW   = SXXW + NW;
  localparam int GW   = SXYW + NW;
  localparam int OW   = SXXW + SYW;
  localparam int NUMW = OW;
  localparam int CW   = XW + VW + 1;

  localparam logic [BW-1:0] NB = BW'(WINDOW);

  swcr_pkg::state_t state, state_next;
  logic             fresh;

  logic [LG-1:0]     wslot;
  logic [WINDOW-1:0] vld;
  logic [XW-1:0]     mem_x [WINDOW];
  logic [YW-1:0]     mem_y [WINDOW];
  logic [XW-1:0]     rd_x;
  logic [YW-1:0]     rd_y;
  logic              rd_v;
  logic [XW-1:0]     ox_w;
  logic [YW-1:0]     oy_w;

  logic          kind;
  logic [XW-1:0] nx, ox, c0;
  logic [YW-1:0] ny, oy;

  logic [SXW-1:0]  sx;
  logic [SYW-1:0]  sy;
  logic [SXXW-1:0] sxx;
  logic [SXYW-1:0] sxy;

  logic [PW-1:0] ra;
  logic [DW-1:0] den;
  logic [GW-1:0] numg;
  logic [OW-1:0] numo;
  logic          sg, so, sneg;

  logic [VW-1:0] gain, offset;
  logic [VW-1:0] est;
  logic          clip;
  logic          ov, oc;
  logic [VW-1:0] og, oo, oe;

  logic            mul_start, mul_done;
  logic [AW-1:0]   mul_a;
  logic [BW-1:0]   mul_b;
  logic [PW-1:0]   mul_prod;
  logic            div_start, div_done;
  logic [NUMW-1:0] div_num;
  logic [NUMW-1:0] div_q;

  logic          rdy, accept, out_free;
  logic          dif_ge;
  logic [PW-1:0] dif;
  logic [VW:0]   div_sat;

  logic [VW-1:0]  gm, om_v;
  logic [CW-1:0]  pm, om;
  logic [CW-1:0]  s_mag;
  logic           s_neg;
  logic [CW:0]    r_rnd;
  logic [VW:0]    cv_sat;

  function automatic logic [VW:0] sat64(input logic [NUMW-1:0] m, input logic neg);
    logic          hi;
    logic [VW-1:0] lim;
    logic [VW-1:0] v;
    hi  = |m[NUMW-1:VW];
    v   = m[VW-1:0];
    lim = neg ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    if (hi || v > lim) begin
      return {1'b1, lim};
    end
    return {1'b0, neg ? (VW'(0) - v) : v};
  endfunction

  swcr_mul #(.AW(AW), .BW(BW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  swcr_div #(.NUMW(NUMW), .DW(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (den),
    .done  (div_done),
    .quo   (div_q)
  );

  assign accept   = item.valid && rdy;
  assign out_free = !ov || result.ready;

  // rows never written read as one
  assign ox_w = rd_v ? rd_x : XW'(1);
  assign oy_w = rd_v ? rd_y : YW'(1);

  // sign-magnitude difference of the held product and the new one
  assign dif_ge = ra >= mul_prod;
  assign dif    = dif_ge ? (ra - mul_prod) : (mul_prod - ra);

  assign div_sat = sat64(div_q, (state == swcr_pkg::ST_UP_DIVG) ? sg : so);

  // convert: |gain|*count combined with offset*2^32, then rounded
  assign gm    = gain[VW-1] ? (VW'(0) - gain) : gain;
  assign om_v  = offset[VW-1] ? (VW'(0) - offset) : offset;
  assign pm    = ra[CW-1:0];
  assign om    = CW'({om_v, {FW{1'b0}}});
  always_comb begin
    if (gain[VW-1] == offset[VW-1]) begin
      s_mag = pm + om;
      s_neg = gain[VW-1];
    end else if (pm >= om) begin
      s_mag = pm - om;
      s_neg = gain[VW-1];
    end else begin
      s_mag = om - pm;
      s_neg = offset[VW-1];
    end
  end
  assign r_rnd  = {1'b0, ra[CW-1:0]} + (CW+1)'(64'd1 << (FW - 1));
  assign cv_sat = sat64(NUMW'(r_rnd[CW:FW]), sneg);

  always_comb begin
    state_next = state;
    case (state)
      swcr_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = item.kind ? swcr_pkg::ST_CV_MUL : swcr_pkg::ST_UP_READ;
        end
      end
      swcr_pkg::ST_UP_READ:  state_next = swcr_pkg::ST_UP_WRITE;
      swcr_pkg::ST_UP_WRITE: state_next = swcr_pkg::ST_UP_XX_OLD;
      swcr_pkg::ST_UP_XX_OLD: if (mul_done) state_next = swcr_pkg::ST_UP_XY_OLD;
      swcr_pkg::ST_UP_XY_OLD: if (mul_done) state_next = swcr_pkg::ST_UP_XX_NEW;
      swcr_pkg::ST_UP_XX_NEW: if (mul_done) state_next = swcr_pkg::ST_UP_XY_NEW;
      swcr_pkg::ST_UP_XY_NEW: if (mul_done) state_next = swcr_pkg::ST_UP_NSXX;
      swcr_pkg::ST_UP_NSXX:   if (mul_done) state_next = swcr_pkg::ST_UP_SXSX;
      swcr_pkg::ST_UP_SXSX:   if (mul_done) state_next = swcr_pkg::ST_UP_CHECK;
      swcr_pkg::ST_UP_CHECK: begin
        state_next = (den == '0) ? swcr_pkg::ST_DG_CC : swcr_pkg::ST_UP_NSXY;
      end
      swcr_pkg::ST_UP_NSXY:   if (mul_done) state_next = swcr_pkg::ST_UP_SXSY;
      swcr_pkg::ST_UP_SXSY:   if (mul_done) state_next = swcr_pkg::ST_UP_SXXSY;
      swcr_pkg::ST_UP_SXXSY:  if (mul_done) state_next = swcr_pkg::ST_UP_SXSXY;
      swcr_pkg::ST_UP_SXSXY:  if (mul_done) state_next = swcr_pkg::ST_UP_DIVG;
      swcr_pkg::ST_DG_CC:     if (mul_done) state_next = swcr_pkg::ST_DG_NCC;
      swcr_pkg::ST_DG_NCC:    if (mul_done) state_next = swcr_pkg::ST_DG_CSY;
      swcr_pkg::ST_DG_CSY:    if (mul_done) state_next = swcr_pkg::ST_UP_DIVG;
      swcr_pkg::ST_UP_DIVG:   if (div_done) state_next = swcr_pkg::ST_UP_DIVO;
      swcr_pkg::ST_UP_DIVO:   if (div_done) state_next = swcr_pkg::ST_RESULT;
      swcr_pkg::ST_CV_MUL:    if (mul_done) state_next = swcr_pkg::ST_CV_ADD;
      swcr_pkg::ST_CV_ADD:    state_next = swcr_pkg::ST_CV_RND;
      swcr_pkg::ST_CV_RND:    state_next = swcr_pkg::ST_RESULT;
      swcr_pkg::ST_RESULT: begin
        if (out_free) begin
          state_next = swcr_pkg::ST_IDLE;
        end
      end
      default: state_next = swcr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rdy       = 1'b0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    case (state)
      swcr_pkg::ST_IDLE: rdy = 1'b1;
      swcr_pkg::ST_UP_XX_OLD: begin
        mul_start = fresh;
        mul_a     = AW'(ox);
        mul_b     = BW'(ox);
      end
      swcr_pkg::ST_UP_XY_OLD: begin
        mul_start = fresh;
        mul_a     = AW'(oy);
        mul_b     = BW'(ox);
      end
      swcr_pkg::ST_UP_XX_NEW: begin
        mul_start = fresh;
        mul_a     = AW'(nx);
        mul_b     = BW'(nx);
      end
      swcr_pkg::ST_UP_XY_NEW: begin
        mul_start = fresh;
        mul_a     = AW'(ny);
        mul_b     = BW'(nx);
      end
      swcr_pkg::ST_UP_NSXX: begin
        mul_start = fresh;
        mul_a     = AW'(sxx);
        mul_b     = NB;
      end
      swcr_pkg::ST_UP_SXSX: begin
        mul_start = fresh;
        mul_a     = AW'(sx);
        mul_b     = BW'(sx);
      end
      swcr_pkg::ST_UP_NSXY: begin
        mul_start = fresh;
        mul_a     = sxy;
        mul_b     = NB;
      end
      swcr_pkg::ST_UP_SXSY: begin
        mul_start = fresh;
        mul_a     = AW'(sy);
        mul_b     = BW'(sx);
      end
      swcr_pkg::ST_UP_SXXSY: begin
        mul_start = fresh;
        mul_a     = AW'(sxx);
        mul_b     = sy;
      end
      swcr_pkg::ST_UP_SXSXY: begin
        mul_start = fresh;
        mul_a     = sxy;
        mul_b     = BW'(sx);
      end
      swcr_pkg::ST_DG_CC: begin
        mul_start = fresh;
        mul_a     = AW'(c0);
        mul_b     = BW'(c0);
      end
      swcr_pkg::ST_DG_NCC: begin
        mul_start = fresh;
        mul_a     = ra[AW-1:0];
        mul_b     = NB;
      end
      swcr_pkg::ST_DG_CSY: begin
        mul_start = fresh;
        mul_a     = AW'(sy);
        mul_b     = BW'(c0);
      end
      swcr_pkg::ST_UP_DIVG: begin
        div_start = fresh;
        div_num   = NUMW'({numg, {FW{1'b0}}});
      end
      swcr_pkg::ST_UP_DIVO: begin
        div_start = fresh;
        div_num   = numo;
      end
      swcr_pkg::ST_CV_MUL: begin
        mul_start = fresh;
        mul_a     = AW'(gm);
        mul_b     = BW'(nx);
      end
      default: ;
    endcase
  end

  // control and fit state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= swcr_pkg::ST_IDLE;
      fresh  <= 1'b0;
      wslot  <= '0;
      vld    <= '0;
      c0     <= XW'(1);
      sx     <= SXW'(WINDOW);
      sy     <= SYW'(WINDOW);
      sxx    <= SXXW'(WINDOW);
      sxy    <= SXYW'(WINDOW);
      gain   <= '0;
      offset <= '0;
      ov     <= 1'b0;
    end else begin
      state <= state_next;
      fresh <= state_next != state;
      if (accept && !item.kind) begin
        wslot <= (wslot == LG'(WINDOW - 1)) ? '0 : wslot + LG'(1);
      end
      if (state == swcr_pkg::ST_UP_WRITE) begin
        vld[wslot] <= 1'b1;
        sx <= sx - SXW'(ox_w) + SXW'(nx);
        sy <= sy - SYW'(oy_w) + SYW'(ny);
        if (wslot == '0) begin
          c0 <= nx;
        end
      end
      if (mul_done) begin
        case (state)
          swcr_pkg::ST_UP_XX_OLD: sxx <= sxx - SXXW'(mul_prod);
          swcr_pkg::ST_UP_XY_OLD: sxy <= sxy - SXYW'(mul_prod);
          swcr_pkg::ST_UP_XX_NEW: sxx <= sxx + SXXW'(mul_prod);
          swcr_pkg::ST_UP_XY_NEW: sxy <= sxy + SXYW'(mul_prod);
          default: ;
        endcase
      end
      if (div_done) begin
        if (state == swcr_pkg::ST_UP_DIVG) begin
          gain <= div_sat[VW-1:0];
        end else begin
          offset <= div_sat[VW-1:0];
        end
      end
      if (state == swcr_pkg::ST_RESULT && out_free) begin
        ov <= 1'b1;
      end else if (result.ready) begin
        ov <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind <= item.kind;
      nx   <= {item.remote_epoch, item.remote_ticks};
      ny   <= item.local_stamp;
      est  <= '0;
      clip <= 1'b0;
    end
    if (state == swcr_pkg::ST_UP_WRITE) begin
      ox <= ox_w;
      oy <= oy_w;
    end
    if (mul_done) begin
      case (state)
        swcr_pkg::ST_UP_NSXX:  ra <= mul_prod;
        swcr_pkg::ST_UP_SXSX:  den <= DW'(ra - mul_prod);
        swcr_pkg::ST_UP_NSXY:  ra <= mul_prod;
        swcr_pkg::ST_UP_SXSY: begin
          numg <= dif[GW-1:0];
          sg   <= !dif_ge;
        end
        swcr_pkg::ST_UP_SXXSY: ra <= mul_prod;
        swcr_pkg::ST_UP_SXSXY: begin
          numo <= dif[OW-1:0];
          so   <= !dif_ge;
        end
        swcr_pkg::ST_DG_CC:    ra <= mul_prod + PW'(1);
        swcr_pkg::ST_DG_NCC:   den <= mul_prod[DW-1:0];
        swcr_pkg::ST_DG_CSY: begin
          numg <= mul_prod[GW-1:0];
          sg   <= 1'b0;
          numo <= OW'(sy);
          so   <= 1'b0;
        end
        swcr_pkg::ST_CV_MUL:   ra <= mul_prod;
        default: ;
      endcase
    end
    if (state == swcr_pkg::ST_CV_ADD) begin
      ra   <= PW'(s_mag);
      sneg <= s_neg;
    end
    if (state == swcr_pkg::ST_CV_RND && kind) begin
      est  <= cv_sat[VW-1:0];
      clip <= cv_sat[VW];
    end
    if (state == swcr_pkg::ST_RESULT && out_free) begin
      og <= gain;
      oo <= offset;
      oe <= est;
      oc <= clip;
    end
  end

  // window rows
  always_ff @(posedge clk) begin
    if (state == swcr_pkg::ST_UP_WRITE) begin
      mem_x[wslot] <= nx;
      mem_y[wslot] <= ny;
    end
    rd_x <= mem_x[wslot];
    rd_y <= mem_y[wslot];
    rd_v <= vld[wslot];
  end

  assign item.ready              = rdy;
  assign result.valid            = ov;
  assign result.gain_now         = og;
  assign result.offset_now       = oo;
  assign result.local_estimate   = oe;
  assign result.estimate_clipped = oc;

endmodule

@@ rtl/swcr_check.sv @@
// swcr_check: port-level checks for the clock regression unit, bound to the
// top level. Depends on swcr_pkg for widths.
module swcr_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [swcr_pkg::VALUE_W-1:0] gain_now,
  input logic [swcr_pkg::VALUE_W-1:0] offset_now,
  input logic [swcr_pkg::VALUE_W-1:0] local_estimate,
  input logic                         estimate_clipped
);

  localparam logic [swcr_pkg::VALUE_W-1:0] MAXV = {1'b0, {(swcr_pkg::VALUE_W-1){1'b1}}};
  localparam logic [swcr_pkg::VALUE_W-1:0] MINV = {1'b1, {(swcr_pkg::VALUE_W-1){1'b0}}};

  // one request in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in work");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before taken");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(gain_now) && $stable(offset_now)
                                && $stable(local_estimate) && $stable(estimate_clipped))
    else $error("stalled result changed");

  // a clipped estimate sits at one of the limits
  a_clip_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && estimate_clipped |-> local_estimate == MAXV || local_estimate == MINV)
    else $error("clipped estimate not at a limit");

endmodule

bind sliding_window_clock_regression_unit swcr_check u_check (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (item.valid),
  .in_ready         (item.ready),
  .out_valid        (result.valid),
  .out_ready        (result.ready),
  .gain_now         (result.gain_now),
  .offset_now       (result.offset_now),
  .local_estimate   (result.local_estimate),
  .estimate_clipped (result.estimate_clipped)
);
